// ===== sv/lpr_pkg.sv =====
// ---------------------------------------------------------------------------
// lpr_pkg
// Shared types, codes and opcode decode helpers for the packet receiver.
// ---------------------------------------------------------------------------
package lpr_pkg;

   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int POS_W      = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int RSP_DATA_W = 16;

   // result status codes (rsp_tuser)
   typedef enum logic [STATUS_W-1:0] {
      ST_STORED   = 3'd0,
      ST_PKT_OUT  = 3'd1,
      ST_INVALID  = 3'd2,
      ST_OVERLONG = 3'd3,
      ST_TICK     = 3'd4,
      ST_TIMEOUT  = 3'd5
   } status_type;

   // input item kinds (req_tuser)
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SILENCE_LIMIT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_POWER_ON      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_POWER_OFF     = 2'd2;

   localparam logic [BYTE_W-1:0] SILENCE_LIMIT_RST = 8'd100;
   localparam logic [BYTE_W-1:0] POWER_ON_RST      = 8'd131;
   localparam logic [BYTE_W-1:0] POWER_OFF_RST     = 8'd130;

   // opcode classes (upper nibble)
   localparam logic [3:0] OPC_LEN2 = 4'h8;
   localparam logic [3:0] OPC_LEN4A = 4'hA;
   localparam logic [3:0] OPC_LEN4B = 4'hB;
   localparam logic [3:0] OPC_LEN6 = 4'hC;
   localparam logic [3:0] OPC_VAR  = 4'hE;
   localparam logic [BYTE_W-1:0] OPC_VAR_BAD = 8'hE0;
   localparam logic [BYTE_W-1:0] LEN_MASK    = 8'h7F;

   typedef struct packed {
      logic accept;   // input transaction this cycle
      logic emit_rd;  // read next packet byte into the result slot
   } ctrl_cmd_type;

   typedef struct packed {
      logic res_free;  // result slot free at the coming edge
      logic complete;  // current input byte completes a packet
      logic rd_last;   // current read index is the final packet byte
   } dp_status_type;

   function automatic logic is_variable(input logic [BYTE_W-1:0] b);
      is_variable = (b[7:4] == OPC_VAR) && (b != OPC_VAR_BAD);
   endfunction

   function automatic logic [BYTE_W-1:0] fixed_length(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] len;
      unique case (b[7:4])
         OPC_LEN2:             len = 8'd2;
         OPC_LEN4A, OPC_LEN4B: len = 8'd4;
         OPC_LEN6:             len = 8'd6;
         default:              len = 8'd0;
      endcase
      fixed_length = len;
   endfunction

endpackage

// ===== sv/loconet_packet_receiver_core.sv =====
// Path: a byte or tick result goes through the result slot, then the output register.
// Throughput: one transaction per cycle while results drain; a completing byte emits its
//   n packet bytes at one per cycle while results drain, from the store's registered read,
//   and req_tready stays low until the last of them is read.
// Reset: synchronous, active high; clears counters, booster flag and valids, and loads
//   the config defaults. The packet store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// loconet_packet_receiver_core
// Frames received bus bytes into packets and emits each completed packet.
// ---------------------------------------------------------------------------
module loconet_packet_receiver_core import lpr_pkg::*; #(
   parameter int PACKET_BYTES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // config write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [BYTE_W-1:0]     csr_wdata,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   input  logic                  req_tuser,   // [0] opcode (0 byte, 1 ms tick)
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] packet_byte, [12:8] byte_position,
                                              // [13] booster_on, [15:14] zero
   output logic [STATUS_W-1:0]   rsp_tuser,   // [2:0] status
   output logic                  rsp_tlast    // last result of the transaction
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // Controller owns the handshake and the emission sequence; the datapath
   // holds the store, framing counters and a result slot ahead of the
   // output register so a new transaction is taken while a result waits.
   lpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lpr_datapath #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/lpr_ctrl.sv =====
// ---------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: gates input transactions and steps packet emission.
// ---------------------------------------------------------------------------
module lpr_ctrl import lpr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready  = (state_ff == S_IDLE) && stat.res_free;
   assign cmd.accept  = req_tvalid && req_tready;
   assign cmd.emit_rd = (state_ff == S_EMIT) && stat.res_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept && stat.complete) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (cmd.emit_rd && stat.rd_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/lpr_datapath.sv =====
// ---------------------------------------------------------------------------
// lpr_datapath
// Packet store, framing counters, config registers and result/output regs.
// ---------------------------------------------------------------------------
module lpr_datapath import lpr_pkg::*; #(
   parameter int PACKET_BYTES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [BYTE_W-1:0]     csr_wdata,
   input  logic                  req_tuser,
   input  logic [BYTE_W-1:0]     req_tdata,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
   localparam int FW = $clog2(PACKET_BYTES + 1);
   localparam int PAD_W = RSP_DATA_W - BYTE_W - POS_W - 1;
   localparam logic [FW-1:0] FILL_MAX = FW'(PACKET_BYTES);
   localparam logic [FW-1:0] FILL_ONE = FW'(1);

   // config
   logic [BYTE_W-1:0] limit_ff, pwr_on_ff, pwr_off_ff;

   // framing state
   logic [FW-1:0]     fill_ff;
   logic [BYTE_W-1:0] exp_len_ff;
   logic [BYTE_W-1:0] silence_ff;
   logic              booster_ff;
   logic [BYTE_W-1:0] first_ff;
   logic [BYTE_W-1:0] store_mem [PACKET_BYTES];

   // emission
   logic [AW-1:0] rd_idx_ff;
   logic [FW-1:0] emit_len_ff;

   // result slot and output register
   logic              res_valid_ff, res_last_ff, res_booster_ff;
   status_type        res_status_ff;
   logic [BYTE_W-1:0] res_byte_ff;
   logic [POS_W-1:0]  res_pos_ff;
   logic              out_valid_ff, out_last_ff, out_booster_ff;
   status_type        out_status_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [POS_W-1:0]  out_pos_ff;

   logic              is_tick, fill_zero, opc_bad, overlong, completes, timeout, rd_last;
   logic              out_free, load_single;
   logic [BYTE_W-1:0] rx, sil_inc, exp_sel, first_sel;
   logic [FW-1:0]     fill_inc;
   status_type        single_status;
   logic [BYTE_W-1:0] single_byte;
   logic [POS_W-1:0]  single_pos;

   assign rx        = req_tdata;
   assign is_tick   = (req_tuser == KIND_TICK);
   assign fill_zero = (fill_ff == '0);
   assign sil_inc   = (silence_ff == '1) ? silence_ff : silence_ff + 8'd1;
   assign timeout   = !fill_zero && (sil_inc > limit_ff);
   assign first_sel = fill_zero ? rx : first_ff;
   assign opc_bad   = fill_zero && (fixed_length(rx) == '0) && !is_variable(rx);
   assign overlong  = (fill_ff >= FILL_MAX);
   assign fill_inc  = fill_ff + FILL_ONE;

   always_comb begin
      priority if (fill_zero) begin
         exp_sel = fixed_length(rx);
      end else if ((fill_ff == FILL_ONE) && is_variable(first_ff)) begin
         exp_sel = rx & LEN_MASK;
      end else begin
         exp_sel = exp_len_ff;
      end
   end

   assign completes = !is_tick && !opc_bad && !overlong && (8'(fill_inc) == exp_sel);
   assign rd_last   = ((FW'(rd_idx_ff) + FILL_ONE) == emit_len_ff);

   always_comb begin
      single_byte = rx;
      single_pos  = '0;
      priority if (is_tick) begin
         single_status = timeout ? ST_TIMEOUT : ST_TICK;
         single_byte   = '0;
      end else if (opc_bad) begin
         single_status = ST_INVALID;
      end else if (overlong) begin
         single_status = ST_OVERLONG;
      end else begin
         single_status = ST_STORED;
         single_pos    = POS_W'(fill_ff);
      end
   end

   assign out_free    = !out_valid_ff || rsp_tready;
   assign load_single = cmd.accept && !completes;

   assign stat.res_free = !res_valid_ff || out_free;
   assign stat.complete = completes;
   assign stat.rd_last  = rd_last;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= SILENCE_LIMIT_RST;
         pwr_on_ff    <= POWER_ON_RST;
         pwr_off_ff   <= POWER_OFF_RST;
         fill_ff      <= '0;
         exp_len_ff   <= '0;
         silence_ff   <= '0;
         booster_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SILENCE_LIMIT: limit_ff   <= csr_wdata;
               CSR_POWER_ON:      pwr_on_ff  <= csr_wdata;
               CSR_POWER_OFF:     pwr_off_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.accept) begin
            if (is_tick) begin
               if (!fill_zero) begin
                  silence_ff <= sil_inc;
                  if (timeout) fill_ff <= '0;
               end
            end else begin
               silence_ff <= '0;
               if (!opc_bad) begin
                  exp_len_ff <= exp_sel;
                  if (overlong || completes) begin
                     fill_ff <= '0;
                  end else begin
                     fill_ff <= fill_inc;
                  end
                  if (completes) begin
                     if (first_sel == pwr_on_ff) begin
                        booster_ff <= 1'b1;
                     end else if (first_sel == pwr_off_ff) begin
                        booster_ff <= 1'b0;
                     end
                  end
               end
            end
         end
         if (cmd.emit_rd || load_single) begin
            res_valid_ff <= 1'b1;
         end else if (out_free) begin
            res_valid_ff <= 1'b0;
         end
         if (out_free) out_valid_ff <= res_valid_ff;
      end
   end

   // packet store: write on stored byte, registered read into the result slot
   always_ff @(posedge clock) begin
      if (cmd.accept && !is_tick && !opc_bad && !overlong) begin
         store_mem[fill_ff[AW-1:0]] <= rx;
      end
      if (cmd.emit_rd) begin
         res_byte_ff <= store_mem[rd_idx_ff];
      end else if (load_single) begin
         res_byte_ff <= single_byte;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept && !is_tick && fill_zero) first_ff <= rx;
      if (cmd.accept && completes) begin
         emit_len_ff <= fill_inc;
         rd_idx_ff   <= '0;
      end else if (cmd.emit_rd) begin
         rd_idx_ff <= rd_idx_ff + AW'(1);
      end
      if (cmd.emit_rd) begin
         res_status_ff  <= ST_PKT_OUT;
         res_pos_ff     <= POS_W'(rd_idx_ff);
         res_last_ff    <= rd_last;
         res_booster_ff <= booster_ff;
      end else if (load_single) begin
         res_status_ff  <= single_status;
         res_pos_ff     <= single_pos;
         res_last_ff    <= 1'b1;
         res_booster_ff <= booster_ff;
      end
      if (out_free && res_valid_ff) begin
         out_status_ff  <= res_status_ff;
         out_byte_ff    <= res_byte_ff;
         out_pos_ff     <= res_pos_ff;
         out_last_ff    <= res_last_ff;
         out_booster_ff <= res_booster_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_booster_ff, out_pos_ff, out_byte_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/lpr_checker.sv =====
// ---------------------------------------------------------------------------
// lpr_checker
// Port-level checks of the packet receiver, bound to the top level.
// ---------------------------------------------------------------------------
module lpr_checker import lpr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser,
   input logic                  rsp_tlast
);

   // nothing on the result side right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // every non-packet status is a single-result transaction
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_PKT_OUT) |-> rsp_tlast)
      else $error("single result without tlast");

   // packets are at least two bytes, so the first byte is never last
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_PKT_OUT) && (rsp_tdata[12:8] == 5'd0)
         && !$past(rsp_tvalid && !rsp_tready) |-> !rsp_tlast)
      else $error("packet of one byte emitted");

endmodule

bind loconet_packet_receiver_core lpr_checker u_lpr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
